>>> hdl/frmc_pkg.sv
`default_nettype none
package frmc_pkg;

    // Fractional values in [0,1] carried as Q1.40.
    localparam int QF = 40;

    typedef logic [QF:0] t_q40;
    typedef t_q40 t_tab32 [32];
    typedef t_q40 t_tab256 [256];

    typedef struct packed {
        logic        done;
        logic [31:0] thr;
    } t_thr_res;

    typedef enum logic [1:0] {
        CFG_INITIAL  = 2'd0,
        CFG_RATE     = 2'd1,
        CFG_RECOVERY = 2'd2,
        CFG_RUN_LEN  = 2'd3
    } t_cfg_idx;

    // exp(-v) in Q1.40, rounded; evaluated at elaboration only.
    function automatic t_q40 exp_q40(real v);
        real r;
        r = $exp(-v) * 1099511627776.0 + 0.5;
        return t_q40'(longint'($floor(r)));
    endfunction

    // exp(-i) for integer i up to 22; unused codes hold zero.
    function automatic t_tab32 gen_int_tab();
        t_tab32 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = (i < 23) ? exp_q40(real'(i)) : '0;
        end
        return t;
    endfunction

    // exp(-a * scale) for an 8-bit slice a of the fraction.
    function automatic t_tab256 gen_frac_tab(real scale);
        t_tab256 t;
        for (int a = 0; a < 256; a++) begin
            t[a] = exp_q40(real'(a) * scale);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

>>> hdl/failure_recovery_monte_carlo_step_core.sv
`default_nettype none
// One time step of a machine failure and recovery process per transfer. For
// each item the failure threshold 1-exp(-rate*N) is built from an integer exp
// table and three fraction tables, multiplied together in a two-pass 41-bit
// multiplier, and the count update then reads, adds and writes back the
// per-index sum and sum-of-squares memories before the result is loaded. The
// input stalls until the result register has taken the result, so a new item
// is not accepted until the last one is through. After reset the block clears
// both memories, one entry a cycle, from address 0 up to MAX_STEPS-1, before
// it accepts the first item; configuration writes are taken at any time.
module failure_recovery_monte_carlo_step_core #(
    parameter int MAX_STEPS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_fail_sample,
    input  wire logic [31:0] i_recover_sample,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_working,
    output logic [11:0]      o_step_index,
    output logic [31:0]      o_sum_working,
    output logic [47:0]      o_sum_squares,
    output logic             o_run_end
);
    import frmc_pkg::*;

    localparam int AW  = $clog2(MAX_STEPS);
    localparam int CL  = $clog2(MAX_STEPS + 1);
    localparam int CW  = (CL > 13) ? CL : 13;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_STEPS - 1);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_THR  = 5'b00100,
        S_UPD  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_initial;
    logic [31:0] r_rate;
    logic [31:0] r_recovery;
    logic [12:0] r_run_len;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_tidx;
    logic [AW-1:0] r_idx;
    logic        r_last;
    logic [15:0] r_count;
    logic [15:0] r_n;
    logic [15:0] r_nw;
    logic [31:0] r_fs, r_rs;
    logic        r_o_valid;

    logic        accept, out_free, wr_en;
    logic [CW-1:0] rl, len_c, idx_e, idx_c;
    logic        last_c;
    logic [15:0] n1, n2;
    logic [31:0] sum_rd, sum_new;
    logic [47:0] sq_rd, sq_new;
    logic [31:0] nsq;
    logic [AW-1:0] wr_addr;
    t_thr_res    thr_res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;
    assign o_valid     = r_o_valid;

    // Run length clamped to 1..MAX_STEPS; a stale index restarts the run.
    always_comb begin
        rl = CW'(r_run_len);
        if (rl == '0) begin
            len_c = CW'(1);
        end else if (rl > CW'(MAX_STEPS)) begin
            len_c = CW'(MAX_STEPS);
        end else begin
            len_c = rl;
        end
        idx_e  = CW'(r_tidx);
        idx_c  = (idx_e >= len_c) ? '0 : idx_e;
        last_c = (idx_c == len_c - CW'(1));
    end

    always_comb begin
        n1 = r_n;
        if (r_n != 16'd0 && r_fs < thr_res.thr) begin
            n1 = r_n - 16'd1;
        end
        n2 = n1;
        if (r_rs < r_recovery && n1 < r_initial) begin
            n2 = n1 + 16'd1;
        end
    end

    assign nsq     = r_nw * r_nw;
    assign sum_new = sum_rd + 32'(r_nw);
    assign sq_new  = sq_rd + 48'(nsq);
    assign wr_en   = (r_state == S_CLR) || (r_state == S_WB && out_free);
    assign wr_addr = (r_state == S_CLR) ? r_clr : r_idx;

    frmc_thr u_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_n     ((idx_c == '0) ? r_initial : r_count),
        .i_rate  (r_rate),
        .o_res   (thr_res)
    );

    frmc_ram #(.WIDTH(32), .DEPTH(MAX_STEPS)) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ((r_state == S_CLR) ? 32'd0 : sum_new),
        .i_rd_addr (r_idx),
        .o_rd_data (sum_rd)
    );

    frmc_ram #(.WIDTH(48), .DEPTH(MAX_STEPS)) u_sq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ((r_state == S_CLR) ? 48'd0 : sq_new),
        .i_rd_addr (r_idx),
        .o_rd_data (sq_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_THR;
            S_THR:  if (thr_res.done) n_state = S_UPD;
            S_UPD:  n_state = S_WB;
            S_WB:   if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_tidx     <= '0;
            r_count    <= '0;
            r_o_valid  <= 1'b0;
            r_initial  <= 16'd100;
            r_rate     <= '0;
            r_recovery <= '0;
            r_run_len  <= 13'd4096;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept) begin
                r_tidx <= last_c ? '0 : AW'(idx_c + CW'(1));
            end
            if (r_state == S_UPD) begin
                r_count <= n2;
            end
            if (r_state == S_WB && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_INITIAL:  r_initial  <= i_cfg_data[15:0];
                    CFG_RATE:     r_rate     <= i_cfg_data;
                    CFG_RECOVERY: r_recovery <= i_cfg_data;
                    CFG_RUN_LEN:  r_run_len  <= i_cfg_data[12:0];
                    default:      r_run_len  <= r_run_len;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= AW'(idx_c);
            r_last <= last_c;
            r_n    <= (idx_c == '0) ? r_initial : r_count;
            r_fs   <= i_fail_sample;
            r_rs   <= i_recover_sample;
        end
        if (r_state == S_UPD) begin
            r_nw <= n2;
        end
        if (r_state == S_WB && out_free) begin
            o_working     <= r_nw;
            o_step_index  <= 12'(r_idx);
            o_sum_working <= sum_new;
            o_sum_squares <= sq_new;
            o_run_end     <= r_last;
        end
    end

    a_load_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_WB))
        else $error("result loaded outside write-back");

    a_no_write_in_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_THR || r_state == S_UPD) |-> !wr_en)
        else $error("memory written during threshold or update");

    a_done_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_THR && thr_res.done) |=> r_state == S_UPD)
        else $error("threshold result not consumed");
endmodule
`default_nettype wire

>>> hdl/frmc_ram.sv
`default_nettype none
module frmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

>>> hdl/frmc_thr.sv
`default_nettype none
module frmc_thr (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_n,
    input  wire logic [31:0] i_rate,
    output frmc_pkg::t_thr_res o_res
);
    import frmc_pkg::*;

    localparam t_tab32  T_INT = gen_int_tab();
    localparam t_tab256 T_F1  = gen_frac_tab(1.0 / 256.0);
    localparam t_tab256 T_F2  = gen_frac_tab(1.0 / 65536.0);
    localparam t_tab256 T_F3  = gen_frac_tab(1.0 / 16777216.0);
    localparam logic [47:0] X_SAT = 48'd23 << 24;

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_LOAD = 5'b00010,
        T_MLO  = 5'b00100,
        T_MHI  = 5'b01000,
        T_OUT  = 5'b10000
    } t_tstate;

    t_tstate     r_state, n_state;
    logic [47:0] r_x;
    logic        r_sat;
    logic [23:0] r_f;
    t_q40        r_acc;
    logic [60:0] r_plo;
    logic [1:0]  r_k;

    t_q40        fac;
    logic [61:0] phi;
    logic [81:0] full;
    logic [40:0] diff;

    always_comb begin
        case (r_k)
            2'd1:    fac = T_F1[r_f[23:16]];
            2'd2:    fac = T_F2[r_f[15:8]];
            default: fac = T_F3[r_f[7:0]];
        endcase
    end

    assign phi  = r_acc * fac[40:20];
    assign full = {phi, 20'b0} + 82'(r_plo);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: if (i_start) n_state = T_LOAD;
            T_LOAD: n_state = T_MLO;
            T_MLO:  n_state = T_MHI;
            T_MHI:  n_state = (r_k == 2'd3) ? T_OUT : T_MLO;
            T_OUT:  n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_k     <= 2'd1;
        end else begin
            r_state <= n_state;
            if (r_state == T_LOAD) begin
                r_k <= 2'd1;
            end else if (r_state == T_MHI && r_k != 2'd3) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && i_start) begin
            r_x <= i_rate * i_n;
        end
        if (r_state == T_LOAD) begin
            r_sat <= (r_x >= X_SAT);
            r_f   <= r_x[23:0];
            r_acc <= T_INT[r_x[28:24]];
        end
        if (r_state == T_MLO) begin
            r_plo <= r_acc * fac[19:0];
        end
        if (r_state == T_MHI) begin
            r_acc <= full[80:40];
        end
    end

    // The threshold is (1 - product) floored to 32 fraction bits, saturating to all ones.
    assign diff = (41'd1 << QF) - r_acc;

    always_comb begin
        o_res.done = (r_state == T_OUT);
        if (r_sat || diff[40]) begin
            o_res.thr = '1;
        end else begin
            o_res.thr = diff[39:8];
        end
    end
endmodule
`default_nettype wire
